@@ design/tmcs_pkg.sv @@
// Shared types and constants of the trimmed-mean load-cell scale.
package tmcs_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CODE_W   = 3;
	localparam int GRAM_W   = 15;
	localparam int CFG_IDX_W = 3;

	localparam logic [CODE_W-1:0] CODE_CH0 = 3'd4;
	localparam logic [CODE_W-1:0] CODE_CH1 = 3'd5;

	localparam logic [1:0] KIND_CH0   = 2'd0;
	localparam logic [1:0] KIND_CH1   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPG0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CPG1   = 3'd4;

	localparam logic [16:0]       GRAM_REJECT = 17'd99000;
	localparam logic [GRAM_W-1:0] GRAM_LIMIT  = 15'd30000;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [CODE_W-1:0]   channel_code;
	} in_item_t;

	typedef struct packed {
		logic                accepted;
		logic [1:0]          channel_kind;
		logic [SAMPLE_W-1:0] filtered_ch0;
		logic [SAMPLE_W-1:0] filtered_ch1;
		logic [GRAM_W-1:0]   grams_ch0;
		logic [GRAM_W-1:0]   grams_ch1;
		logic [GRAM_W-1:0]   grams_selected;
	} out_item_t;

	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ design/tmcs_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module tmcs_div
	import tmcs_pkg::*;
#(
	parameter int W = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  div_req_t     req,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output div_stat_t    stat,
	output logic [W-1:0] quot
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule

@@ design/trimmed_mean_load_cell_scale.sv @@
// Top level of the two-channel trimmed-mean load-cell scale.
//
// Use: conversions arrive on the input channel (in_valid, in_stall, in_data);
// one result transfer leaves on the output channel for every input transfer.
// Code 4 feeds channel zero and code 5 feeds channel one; a zero sample is
// reported but changes nothing, and any other code only recomputes the grams.
// Both windows sit in one synchronous memory as circular buffers, one region
// per channel. An updating sample is written over the oldest entry, then the
// whole window is read out once, one entry per cycle, while a running total
// and two short sorted lists (largest and smallest entries) are kept. The
// trimmed sum is scaled by a fixed reciprocal to give the mean, and an
// iterative divider, one bit a cycle, then forms each channel's grams.
// A channel whose weight is plainly zero skips its division. One item is in
// work at a time; in_stall is low only while idle. A result waits in the
// output register while the receiver stalls, and a new item may be taken
// meanwhile. The user must see that configuration is written while idle only;
// the block itself does not enforce this. Reset returns both scale factors to
// one and clears the rest of the configuration, the averages, the pointers
// and the per-entry valid bits.
module trimmed_mean_load_cell_scale
	import tmcs_pkg::*;
#(
	parameter int WINDOW_LEN = 48,
	parameter int TRIM_HIGH  = 4,
	parameter int TRIM_LOW   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data
);

	localparam int IW       = $clog2(WINDOW_LEN);
	localparam int AW       = IW + 1;
	localparam int DEPTH    = 2 ** AW;
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int KEPT     = WINDOW_LEN - TRIM_HIGH - TRIM_LOW;
	localparam int KEPT_DIV = (KEPT > 0) ? KEPT : 1;
	localparam int TH       = (TRIM_HIGH > 0) ? TRIM_HIGH : 1;
	localparam int TL       = (TRIM_LOW > 0) ? TRIM_LOW : 1;
	localparam bit TOP_EN   = (TRIM_HIGH > 0);
	localparam bit BOT_EN   = (TRIM_LOW > 0);
	localparam bit KEPT_EN  = (KEPT > 0);

	// The mean is the kept sum times a rounded-up reciprocal of the kept count,
	// shifted down; this is exact for every sum below 2 ** SUM_W.
	localparam int MSH = SUM_W + $clog2(KEPT_DIV);
	localparam int RW  = SUM_W + 1;
	localparam int PW  = SUM_W + RW;
	localparam longint unsigned RECIP =
		((64'd1 << MSH) + 64'(KEPT_DIV) - 64'd1) / 64'(KEPT_DIV);
	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_WRITE = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_MEAN  = 8'b0001_0000,
		S_G0    = 8'b0010_0000,
		S_G1    = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic                sel_q;
	logic [SAMPLE_W-1:0] base_q [2];
	logic [SAMPLE_W-1:0] cpg_q [2];

	// Item in work.
	logic [SAMPLE_W-1:0] sample_q;
	logic                accepted_q;
	logic [1:0]          kind_q;
	logic                wch_q;

	// Channel state kept in flip-flops.
	logic [SAMPLE_W-1:0] avg_q [2];
	logic [IW-1:0]       wptr_q [2];
	logic [GRAM_W-1:0]   grams_q [2];

	// Window memory with one valid bit per entry.
	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    mem_v_q;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic                rvalid_s1;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_cnt_q;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;

	// Window statistics.
	logic [SUM_W-1:0]    total_q;
	logic [SUM_W-1:0]    topsum_q;
	logic [SUM_W-1:0]    botsum_q;
	logic [SAMPLE_W-1:0] top_q [TH];
	logic [TH-1:0]       top_v_q;
	logic [TH-1:0]       top_ins;
	logic [SAMPLE_W-1:0] bot_q [TL];
	logic [TL-1:0]       bot_v_q;
	logic [TL-1:0]       bot_ins;
	logic [SAMPLE_W-1:0] rv;
	logic [SAMPLE_W-1:0] top_evict;
	logic [SAMPLE_W-1:0] bot_evict;
	logic [SUM_W-1:0]    kept_sum;

	// Mean by reciprocal multiplication.
	logic [SUM_W-1:0]    kept_q;
	logic                mean_ph_q;
	logic [PW-1:0]       mean_prod;

	// Divider.
	div_req_t         div_req;
	div_stat_t        div_stat;
	logic [SUM_W-1:0] div_dividend;
	logic [SUM_W-1:0] div_divisor;
	logic [SUM_W-1:0] div_quot;
	logic             div_go_q;

	// Grams of the channel being worked on.
	logic                gch;
	logic                g_zero;
	logic [SAMPLE_W-1:0] g_diff;
	logic [GRAM_W-1:0]   g_clamped;

	logic in_xfer;
	logic out_free;
	logic upd;
	logic out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign upd = (in_data.sample != '0) &&
		((in_data.channel_code == CODE_CH0) || (in_data.channel_code == CODE_CH1));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			base_q[0] <= '0;
			base_q[1] <= '0;
			cpg_q[0]  <= SAMPLE_W'(1);
			cpg_q[1]  <= SAMPLE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SELECT: sel_q     <= cfg_data[0];
				REG_BASE0:  base_q[0] <= cfg_data;
				REG_CPG0:   cpg_q[0]  <= cfg_data;
				REG_BASE1:  base_q[1] <= cfg_data;
				REG_CPG1:   cpg_q[1]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memory addressing: the channel picks the region, the pointer the entry.
	assign waddr = {wch_q, wptr_q[wch_q]};
	assign raddr = {wch_q, rd_cnt_q};

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			mem[waddr] <= sample_q;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_v_q   <= '0;
			rvalid_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == S_WRITE) begin
				mem_v_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= mem_v_q[raddr];
			rd_vld_s1 <= (state_q == S_READ);
		end
	end

	// An entry never written reads as zero.
	assign rv = rvalid_s1 ? rdata_s1 : '0;

	// Sorted lists: the largest entries in descending order, the smallest in
	// ascending order. An empty slot always takes the new value.
	always_comb begin
		for (int i = 0; i < TH; i++) begin
			top_ins[i] = !top_v_q[i] || (rv > top_q[i]);
		end
		for (int i = 0; i < TL; i++) begin
			bot_ins[i] = !bot_v_q[i] || (rv < bot_q[i]);
		end
		top_evict = top_v_q[TH-1] ? top_q[TH-1] : '0;
		bot_evict = bot_v_q[TL-1] ? bot_q[TL-1] : '0;
	end

	for (genvar i = 0; i < TH; i++) begin : g_top
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (rd_vld_s1 && top_ins[0]) begin
					top_q[0] <= rv;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (rd_vld_s1 && top_ins[i]) begin
					top_q[i] <= top_ins[i-1] ? top_q[i-1] : rv;
				end
			end
		end
	end

	for (genvar i = 0; i < TL; i++) begin : g_bot
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (rd_vld_s1 && bot_ins[0]) begin
					bot_q[0] <= rv;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (rd_vld_s1 && bot_ins[i]) begin
					bot_q[i] <= bot_ins[i-1] ? bot_q[i-1] : rv;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_v_q  <= '0;
			bot_v_q  <= '0;
			total_q  <= '0;
			topsum_q <= '0;
			botsum_q <= '0;
		end else if (state_q == S_WRITE) begin
			top_v_q  <= '0;
			bot_v_q  <= '0;
			total_q  <= '0;
			topsum_q <= '0;
			botsum_q <= '0;
		end else if (rd_vld_s1) begin
			total_q <= total_q + SUM_W'(rv);
			if (TOP_EN && top_ins[TH-1]) begin
				top_v_q  <= (top_v_q << 1) | TH'(1);
				topsum_q <= topsum_q + SUM_W'(rv) - SUM_W'(top_evict);
			end
			if (BOT_EN && bot_ins[TL-1]) begin
				bot_v_q  <= (bot_v_q << 1) | TL'(1);
				botsum_q <= botsum_q + SUM_W'(rv) - SUM_W'(bot_evict);
			end
		end
	end

	assign kept_sum  = total_q - topsum_q - botsum_q;
	assign mean_prod = {{RW{1'b0}}, kept_q} * {{SUM_W{1'b0}}, RECIP_C};

	// Grams of one channel: zero when the average is at or below the tare or
	// the scale factor is zero; the quotient is then rejected or saturated.
	assign gch    = (state_q == S_G1);
	assign g_zero = (cpg_q[gch] == '0) || (avg_q[gch] <= base_q[gch]);
	assign g_diff = avg_q[gch] - base_q[gch];

	always_comb begin
		if (div_quot > SUM_W'(GRAM_REJECT)) begin
			g_clamped = '0;
		end else if (div_quot > SUM_W'(GRAM_LIMIT)) begin
			g_clamped = GRAM_LIMIT;
		end else begin
			g_clamped = div_quot[GRAM_W-1:0];
		end
	end

	assign div_dividend = SUM_W'(g_diff);
	assign div_divisor  = SUM_W'(cpg_q[gch]);

	assign div_req.start = !div_go_q &&
		((state_q == S_G0) || (state_q == S_G1)) && !g_zero;

	tmcs_div #(
		.W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_go_q    <= 1'b0;
			rd_cnt_q    <= '0;
			wptr_q[0]   <= '0;
			wptr_q[1]   <= '0;
			avg_q[0]    <= '0;
			avg_q[1]    <= '0;
			out_valid_q <= 1'b0;
			wch_q       <= 1'b0;
			kept_q      <= '0;
			mean_ph_q   <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (div_req.start) begin
				div_go_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						wch_q   <= (in_data.channel_code == CODE_CH1);
						state_q <= upd ? S_WRITE : S_G0;
					end
				end
				S_WRITE: begin
					wptr_q[wch_q] <= (wptr_q[wch_q] == IW'(WINDOW_LEN - 1)) ?
						'0 : wptr_q[wch_q] + 1'b1;
					rd_cnt_q <= '0;
					state_q  <= S_READ;
				end
				S_READ: begin
					if (rd_cnt_q == IW'(WINDOW_LEN - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_MEAN;
				end
				S_MEAN: begin
					// The first phase registers the kept sum, the second takes the product; with nothing kept the average is zero.
					if (!KEPT_EN) begin
						avg_q[wch_q] <= '0;
						state_q      <= S_G0;
					end else if (!mean_ph_q) begin
						kept_q    <= kept_sum;
						mean_ph_q <= 1'b1;
					end else begin
						avg_q[wch_q] <= mean_prod[MSH +: SAMPLE_W];
						mean_ph_q    <= 1'b0;
						state_q      <= S_G0;
					end
				end
				S_G0: begin
					if (g_zero) begin
						state_q <= S_G1;
					end else if (div_stat.done) begin
						div_go_q <= 1'b0;
						state_q  <= S_G1;
					end
				end
				S_G1: begin
					if (g_zero || div_stat.done) begin
						div_go_q <= 1'b0;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q   <= in_data.sample;
			accepted_q <= (in_data.sample != '0);
			if (in_data.sample == '0 || in_data.channel_code == CODE_CH0) begin
				kind_q <= KIND_CH0;
			end else if (in_data.channel_code == CODE_CH1) begin
				kind_q <= KIND_CH1;
			end else begin
				kind_q <= KIND_OTHER;
			end
		end
		if (state_q == S_G0) begin
			grams_q[0] <= g_zero ? '0 : g_clamped;
		end
		if (state_q == S_G1) begin
			grams_q[1] <= g_zero ? '0 : g_clamped;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_data.accepted       <= accepted_q;
			out_data.channel_kind   <= kind_q;
			out_data.filtered_ch0   <= avg_q[0];
			out_data.filtered_ch1   <= avg_q[1];
			out_data.grams_ch0      <= grams_q[0];
			out_data.grams_ch1      <= grams_q[1];
			out_data.grams_selected <= sel_q ? grams_q[1] : grams_q[0];
		end
	end

`ifndef SYNTHESIS
	// The divider is always finished by the time the block goes idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_stat.busy)
		else $error("divider busy while idle");

	// Read data only arrives during the window pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ((state_q == S_READ) || (state_q == S_DRAIN)))
		else $error("window read data outside the read pass");

	// Finishing an item with room at the output always presents a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free) |=> out_valid_q)
		else $error("finished item produced no result");
`endif

endmodule

@@ tb/trimmed_mean_load_cell_scale_tb.sv @@
// Self-checking testbench of the two-channel trimmed-mean load-cell scale.
`timescale 1ns / 100ps

module trimmed_mean_load_cell_scale_tb;
	import tmcs_pkg::*;

	localparam int WIN        = 48;
	localparam int TRIM_HI    = 4;
	localparam int TRIM_LO    = 4;
	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM   = 850;
	localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
	localparam int N_PHASES   = 4;
	localparam int SETTLE     = 400;
	localparam int CYCLE_CAP  = 1000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SELECT;
	logic [SAMPLE_W-1:0]  cfg_data = '0;

	trimmed_mean_load_cell_scale u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the scale: configuration, both sliding windows and the averages.
	logic                sel_ch1;
	logic [SAMPLE_W-1:0] tare [2];
	logic [SAMPLE_W-1:0] cpg [2];
	logic [SAMPLE_W-1:0] win0 [WIN];
	logic [SAMPLE_W-1:0] win1 [WIN];
	logic [SAMPLE_W-1:0] avg [2];

	out_item_t expected_results[$];
	int  mismatches = 0;
	int  in_count = 0;
	int  out_count = 0;
	int  cycles = 0;
	int  sender_idle_pct = 0;
	int  receiver_idle_pct = 0;
	bit  hold_done = 1'b0;

	// Shifts a sample into a window and returns the mean of what survives the trim.
	function automatic logic [SAMPLE_W-1:0] trimmed_mean(ref logic [SAMPLE_W-1:0] w [WIN],
			input logic [SAMPLE_W-1:0] value);
		logic [SAMPLE_W-1:0] ordered [WIN];
		logic [SAMPLE_W-1:0] v;
		logic [63:0] sum;
		int j;
		for (int i = 0; i < WIN - 1; i++) begin
			w[i] = w[i + 1];
		end
		w[WIN - 1] = value;
		for (int i = 0; i < WIN; i++) begin
			v = w[i];
			j = i;
			while (j > 0 && ordered[j - 1] > v) begin
				ordered[j] = ordered[j - 1];
				j--;
			end
			ordered[j] = v;
		end
		sum = '0;
		for (int i = TRIM_LO; i < WIN - TRIM_HI; i++) begin
			sum += ordered[i];
		end
		return SAMPLE_W'(sum / (WIN - TRIM_HI - TRIM_LO));
	endfunction

	// Grams with the reject window above 99000 and saturation at 30000.
	function automatic logic [GRAM_W-1:0] clamped_grams(logic [SAMPLE_W-1:0] a,
			logic [SAMPLE_W-1:0] b, logic [SAMPLE_W-1:0] c);
		logic [SAMPLE_W-1:0] q;
		if (c == '0 || a <= b) begin
			return '0;
		end
		q = (a - b) / c;
		if (q > GRAM_REJECT) begin
			return '0;
		end
		if (q > GRAM_LIMIT) begin
			return GRAM_LIMIT;
		end
		return GRAM_W'(q);
	endfunction

	function automatic out_item_t weigh(in_item_t it);
		out_item_t r;
		r = '0;
		if (it.sample != '0) begin
			r.accepted = 1'b1;
			if (it.channel_code == CODE_CH0) begin
				avg[0] = trimmed_mean(win0, it.sample);
				r.channel_kind = KIND_CH0;
			end else if (it.channel_code == CODE_CH1) begin
				avg[1] = trimmed_mean(win1, it.sample);
				r.channel_kind = KIND_CH1;
			end else begin
				r.channel_kind = KIND_OTHER;
			end
		end else begin
			r.channel_kind = KIND_CH0;
		end
		r.filtered_ch0 = avg[0];
		r.filtered_ch1 = avg[1];
		r.grams_ch0 = clamped_grams(avg[0], tare[0], cpg[0]);
		r.grams_ch1 = clamped_grams(avg[1], tare[1], cpg[1]);
		r.grams_selected = sel_ch1 ? r.grams_ch1 : r.grams_ch0;
		return r;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SELECT: sel_ch1 = value[0];
			REG_BASE0:  tare[0] = value;
			REG_CPG0:   cpg[0] = value;
			REG_BASE1:  tare[1] = value;
			REG_CPG1:   cpg[1] = value;
			default: ;
		endcase
	endtask

	// Offers one item from a falling edge and holds it until the transfer happens.
	// The expectation is queued at the accepting edge; a typed-in one overrides the predictor.
	task automatic offer(in_item_t it, bit typed, out_item_t want);
		out_item_t predicted;
		sender_idle_pct = (in_count * 3 < N_TOTAL) ? 38 :
			(in_count * 3 < 2 * N_TOTAL) ? 88 : 0;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (in_stall);
		predicted = weigh(it);
		expected_results.push_back(typed ? want : predicted);
		in_count++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					out_count, name, want, got);
			end
		end
	endtask

	// Receiver: stalls at random per idling phase; once it holds off for a long stretch so that
	// the output register and the block both fill and the input side stalls.
	initial begin
		int held;
		forever begin
			@(negedge clk);
			if (!hold_done && in_count >= 300) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					@(negedge clk);
				end
			end
			receiver_idle_pct = (in_count * 3 < N_TOTAL) ? 88 :
				(in_count * 3 < 2 * N_TOTAL) ? 38 : 0;
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Every result transfer is checked against the oldest expectation, field by field.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d arrived with nothing expected", out_count);
				end
			end else begin
				want = expected_results.pop_front();
				note_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
				note_field("channel_kind", 32'(want.channel_kind),
					32'(out_data.channel_kind));
				note_field("filtered_ch0", 32'(want.filtered_ch0),
					32'(out_data.filtered_ch0));
				note_field("filtered_ch1", 32'(want.filtered_ch1),
					32'(out_data.filtered_ch1));
				note_field("grams_ch0", 32'(want.grams_ch0), 32'(out_data.grams_ch0));
				note_field("grams_ch1", 32'(want.grams_ch1), 32'(out_data.grams_ch1));
				note_field("grams_selected", 32'(want.grams_selected),
					32'(out_data.grams_selected));
			end
			out_count++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic [CODE_W-1:0]   code;
		bit                  typed;
		out_item_t           want;
	} stim_row_t;

	stim_row_t directed [N_DIRECTED];

	// A reading sits near a slowly changing load in grams above the tare, below it if negative.
	function automatic logic [SAMPLE_W-1:0] reading(int ch, int load);
		logic [63:0] raw;
		if (load < 0) begin
			raw = (tare[ch] > 2000) ? tare[ch] - $urandom_range(1, 2000) : 64'd1;
		end else begin
			raw = tare[ch] + 64'(cpg[ch]) * load + $urandom_range(0, 63);
		end
		if (raw > SAMPLE_MAX || raw == 0) begin
			raw = 64'($urandom_range(1, SAMPLE_MAX));
		end
		return SAMPLE_W'(raw);
	endfunction

	initial begin
		in_item_t it;
		int load [2];
		int pick;
		int ch;
		sel_ch1 = 1'b0;
		tare[0] = '0;
		tare[1] = '0;
		cpg[0] = SAMPLE_W'(1);
		cpg[1] = SAMPLE_W'(1);
		avg[0] = '0;
		avg[1] = '0;
		for (int i = 0; i < WIN; i++) begin
			win0[i] = '0;
			win1[i] = '0;
		end

		// Directed table. The first rows start from empty windows, so a single sample is trimmed
		// away and every average and weight reads zero; those expectations are typed in.
		for (int i = 0; i < N_DIRECTED; i++) begin
			directed[i].sample = SAMPLE_MAX;
			directed[i].code = CODE_CH0;
			directed[i].typed = 1'b0;
			directed[i].want = '0;
		end
		directed[0] = '{'0, CODE_CH0, 1'b1, '{1'b0, KIND_CH0, 0, 0, 0, 0, 0}};
		directed[1] = '{SAMPLE_MAX, CODE_CH0, 1'b1, '{1'b1, KIND_CH0, 0, 0, 0, 0, 0}};
		directed[2] = '{SAMPLE_MAX, CODE_CH1, 1'b1, '{1'b1, KIND_CH1, 0, 0, 0, 0, 0}};
		directed[3] = '{24'd1, 3'd0, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		directed[4] = '{SAMPLE_MAX, 3'd7, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		directed[5] = '{24'h800000, 3'd3, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		directed[6] = '{24'h555555, 3'd1, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		directed[7] = '{24'hAAAAAA, 3'd2, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		directed[8] = '{24'd77, 3'd6, 1'b1, '{1'b1, KIND_OTHER, 0, 0, 0, 0, 0}};
		// Rows 9 to 16 keep feeding full-scale samples to channel zero until they outlast the trim;
		// the average then climbs and the weight falls into the reject band.
		directed[17] = '{24'd1, CODE_CH1, 1'b0, '0};
		directed[18] = '{24'h555555, CODE_CH1, 1'b0, '0};
		directed[19] = '{24'hAAAAAA, CODE_CH1, 1'b0, '0};
		directed[20] = '{'0, CODE_CH1, 1'b0, '0};
		directed[21] = '{24'd1, CODE_CH0, 1'b0, '0};
		directed[22] = '{'0, 3'd7, 1'b0, '0};
		directed[23] = '{24'd30000, CODE_CH0, 1'b0, '0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			it.sample = directed[i].sample;
			it.channel_code = directed[i].code;
			offer(it, directed[i].typed, directed[i].want);
		end

		load[0] = 0;
		load[1] = 0;
		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			// Each phase writes every register; extremes of tare and scale appear, as does a zero
			// scale factor, which must force that channel's weight to zero.
			case (phase)
				0: begin
					cfg_write(REG_SELECT, 24'd1);
					cfg_write(REG_BASE0, 24'd100000);
					cfg_write(REG_CPG0, 24'd100);
					cfg_write(REG_BASE1, SAMPLE_MAX);
					cfg_write(REG_CPG1, SAMPLE_MAX);
				end
				1: begin
					cfg_write(REG_SELECT, 24'd0);
					cfg_write(REG_BASE0, 24'd0);
					cfg_write(REG_CPG0, 24'd1);
					cfg_write(REG_BASE1, 24'd2000000);
					cfg_write(REG_CPG1, 24'd37);
				end
				2: begin
					cfg_write(REG_SELECT, 24'd1);
					cfg_write(REG_BASE0, SAMPLE_W'($urandom_range(0, 8000000)));
					cfg_write(REG_CPG0, SAMPLE_W'($urandom_range(1, 150)));
					cfg_write(REG_BASE1, SAMPLE_W'($urandom_range(0, 8000000)));
					cfg_write(REG_CPG1, SAMPLE_W'($urandom_range(1, 150)));
				end
				default: begin
					cfg_write(REG_SELECT, 24'd0);
					cfg_write(REG_BASE0, 24'd5000000);
					cfg_write(REG_CPG0, 24'd0);
					cfg_write(REG_BASE1, 24'd1);
					cfg_write(REG_CPG1, 24'd1);
				end
			endcase

			for (int n = 0; n < N_RANDOM / N_PHASES + (phase == 0 ? N_RANDOM % N_PHASES : 0);
					n++) begin
				pick = $urandom_range(99);
				ch = $urandom_range(1);
				if ($urandom_range(99) < 3) begin
					load[ch] = int'($urandom_range(0, 125000)) - 5000;
				end
				if (pick < 80) begin
					it.sample = reading(ch, load[ch]);
					it.channel_code = ch ? CODE_CH1 : CODE_CH0;
				end else if (pick < 88) begin
					it.sample = '0;
					it.channel_code = CODE_W'($urandom_range(7));
				end else if (pick < 95) begin
					it.sample = SAMPLE_W'($urandom_range(SAMPLE_MAX));
					it.channel_code = CODE_W'($urandom_range(7));
				end else begin
					// Wild conversions on a weighing channel land in the trimmed tails.
					it.sample = SAMPLE_W'($urandom_range(1, SAMPLE_MAX));
					it.channel_code = ch ? CODE_CH1 : CODE_CH0;
				end
				offer(it, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
